/* design/mfvc_pkg.sv */
package mfvc_pkg;

   localparam int MAX_OCTETS = 32;
   localparam int ADDR_W     = $clog2(MAX_OCTETS);
   localparam int CNT_W      = $clog2(MAX_OCTETS + 1);

   localparam logic [1:0] OP_LOAD_FIRST  = 2'd0;
   localparam logic [1:0] OP_LOAD_SECOND = 2'd1;
   localparam logic [1:0] OP_LOAD_MASK   = 2'd2;
   localparam logic [1:0] OP_COMPARE     = 2'd3;

   localparam logic signed [1:0] ORDER_FIRST  = -2'sd1;
   localparam logic signed [1:0] ORDER_EQUAL  = 2'sd0;
   localparam logic signed [1:0] ORDER_SECOND = 2'sd1;

   localparam logic [6:0] LOW_MASK = 7'h7F;

   typedef enum logic [2:0] {
      KIND_EQUAL,
      KIND_MORE_INFO,
      KIND_LONGER,
      KIND_NUMERIC,
      KIND_MALFORMED
   } kind_type;

   typedef enum logic [2:0] {
      WS_IDLE,
      WS_LOOP,
      WS_SKIP_FIRST,
      WS_SKIP_SECOND,
      WS_MASK_SKIP
   } walk_state_type;

   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [ADDR_W-1:0] addr_type;

   typedef struct packed {
      count_type first;
      count_type second;
      count_type mask;
   } lens_type;

   typedef struct packed {
      addr_type first;
      addr_type second;
      addr_type mask;
   } rd_addr_type;

   typedef struct packed {
      logic [7:0] first;
      logic [7:0] second;
      logic [7:0] mask;
   } rd_data_type;

   typedef struct packed {
      logic              valid;
      logic signed [1:0] order;
      kind_type          kind;
   } verdict_type;

endpackage

/* design/masked_feature_vector_compare_core.sv */
// channel   ports                            handshake
// request   req_opcode, req_octet            start & !busy
// response  rsp_order, rsp_kind, rsp_overflow rsp_valid, one cycle, no backpressure
//
// Loads may be issued back to back.
// A compare holds busy while it walks octet pairs, skips vector or mask octets,
// steps past group ends while mask octets remain and past group-end mismatches,
// and through the verdict (the deciding pair on a numeric difference).
// The result strobes in the same cycle that busy falls.
// Reset clears counts, overflow flag and the walker; buffer contents stay.
module masked_feature_vector_compare_core import mfvc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_opcode,
   input  logic [7:0]        req_octet,
   output logic              rsp_valid,
   output logic signed [1:0] rsp_order,
   output logic [2:0]        rsp_kind,
   output logic              rsp_overflow
);

   logic [7:0] first_mem  [MAX_OCTETS];
   logic [7:0] second_mem [MAX_OCTETS];
   logic [7:0] mask_mem   [MAX_OCTETS];

   count_type   first_count_ff, first_count_in;
   count_type   second_count_ff, second_count_in;
   count_type   mask_count_ff, mask_count_in;
   logic        overflow_ff, overflow_in;
   logic        rsp_valid_ff;
   logic signed [1:0] rsp_order_ff;
   kind_type    rsp_kind_ff;
   logic        rsp_overflow_ff;

   logic        accept, go;
   logic        wr_first, wr_second, wr_mask;
   logic        full_first, full_second, full_mask;
   lens_type    lens;
   rd_addr_type rd_addr;
   rd_data_type rd_data_ff;
   verdict_type verdict;

   assign accept      = start && !busy;
   assign go          = accept && (req_opcode == OP_COMPARE);
   assign full_first  = (first_count_ff == count_type'(MAX_OCTETS));
   assign full_second = (second_count_ff == count_type'(MAX_OCTETS));
   assign full_mask   = (mask_count_ff == count_type'(MAX_OCTETS));
   assign wr_first    = accept && (req_opcode == OP_LOAD_FIRST) && !full_first;
   assign wr_second   = accept && (req_opcode == OP_LOAD_SECOND) && !full_second;
   assign wr_mask     = accept && (req_opcode == OP_LOAD_MASK) && !full_mask;

   assign lens.first  = first_count_ff;
   assign lens.second = second_count_ff;
   assign lens.mask   = mask_count_ff;

   mfvc_walk u_walk (
      .clock   (clock),
      .reset   (reset),
      .go      (go),
      .lens    (lens),
      .rd_data (rd_data_ff),
      .rd_addr (rd_addr),
      .verdict (verdict),
      .busy    (busy)
   );

   always_ff @(posedge clock) begin
      if (wr_first)  first_mem[first_count_ff[ADDR_W-1:0]] <= req_octet;
      if (wr_second) second_mem[second_count_ff[ADDR_W-1:0]] <= req_octet;
      if (wr_mask)   mask_mem[mask_count_ff[ADDR_W-1:0]] <= req_octet;
      rd_data_ff.first  <= first_mem[rd_addr.first];
      rd_data_ff.second <= second_mem[rd_addr.second];
      rd_data_ff.mask   <= mask_mem[rd_addr.mask];
   end

   always_comb begin
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      mask_count_in   = mask_count_ff;
      overflow_in     = overflow_ff;
      if (wr_first)  first_count_in  = first_count_ff + count_type'(1);
      if (wr_second) second_count_in = second_count_ff + count_type'(1);
      if (wr_mask)   mask_count_in   = mask_count_ff + count_type'(1);
      // a load into a full buffer is dropped
      if (accept && req_opcode != OP_COMPARE && !wr_first && !wr_second && !wr_mask)
         overflow_in = 1'b1;
      if (verdict.valid) begin
         first_count_in  = '0;
         second_count_in = '0;
         mask_count_in   = '0;
         overflow_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_count_ff  <= '0;
         second_count_ff <= '0;
         mask_count_ff   <= '0;
         overflow_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         mask_count_ff   <= mask_count_in;
         overflow_ff     <= overflow_in;
         rsp_valid_ff    <= verdict.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (verdict.valid) begin
         rsp_order_ff    <= verdict.order;
         rsp_kind_ff     <= verdict.kind;
         rsp_overflow_ff <= overflow_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_order    = rsp_order_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule

/* design/mfvc_walk.sv */
module mfvc_walk import mfvc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  lens_type    lens,
   input  rd_data_type rd_data,
   output rd_addr_type rd_addr,
   output verdict_type verdict,
   output logic        busy
);

   walk_state_type    state_ff, state_in;
   count_type         i_ff, i_in, j_ff, j_in, m_ff, m_in;
   count_type         l1_ff, l1_in, l2_ff, l2_in, ml_ff, ml_in;
   logic signed [1:0] diff_ff, diff_in;
   logic              mskip_ff, mskip_in;

   logic       a_end, b_end, mk_end;
   logic       mask_left, loop_end, num_hit, end_mis, adv;
   logic [6:0] key, a_key, b_key;

   assign a_end     = rd_data.first[7];
   assign b_end     = rd_data.second[7];
   assign mk_end    = rd_data.mask[7];
   assign mask_left = (ml_ff != '0);
   assign loop_end  = (l1_ff == '0) || (l2_ff == '0);
   // an empty mask compares all seven low bits
   assign key       = mask_left ? rd_data.mask[6:0] : LOW_MASK;
   assign a_key     = rd_data.first[6:0] & key;
   assign b_key     = rd_data.second[6:0] & key;
   assign num_hit   = !mskip_ff && (a_key != b_key);
   assign end_mis   = a_end ^ b_end;

   assign busy = (state_ff != WS_IDLE);

   // reads always target the next index, so data lines up with the held index
   assign rd_addr.first  = i_in[ADDR_W-1:0];
   assign rd_addr.second = j_in[ADDR_W-1:0];
   assign rd_addr.mask   = m_in[ADDR_W-1:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         WS_IDLE: begin
            if (go) state_in = WS_LOOP;
         end
         WS_LOOP: begin
            if (loop_end || num_hit) state_in = WS_IDLE;
            else if (end_mis) state_in = a_end ? WS_SKIP_SECOND : WS_SKIP_FIRST;
            else if (a_end && mask_left) state_in = WS_MASK_SKIP;
         end
         WS_SKIP_SECOND: begin
            if (l2_ff != '0 && !b_end) state_in = WS_SKIP_SECOND;
            else if (l2_ff == '0) state_in = WS_IDLE;
            else if (mask_left) state_in = WS_MASK_SKIP;
            else state_in = WS_LOOP;
         end
         WS_SKIP_FIRST: begin
            if (l1_ff != '0 && !a_end) state_in = WS_SKIP_FIRST;
            else if (l1_ff == '0) state_in = WS_IDLE;
            else if (mask_left) state_in = WS_MASK_SKIP;
            else state_in = WS_LOOP;
         end
         WS_MASK_SKIP: begin
            if (mask_left && !mk_end) state_in = WS_MASK_SKIP;
            else state_in = WS_LOOP;
         end
         default: state_in = WS_IDLE;
      endcase
   end

   always_comb begin
      i_in          = i_ff;
      j_in          = j_ff;
      m_in          = m_ff;
      l1_in         = l1_ff;
      l2_in         = l2_ff;
      ml_in         = ml_ff;
      diff_in       = diff_ff;
      mskip_in      = mskip_ff;
      adv           = 1'b0;
      verdict.valid = 1'b0;
      verdict.order = ORDER_EQUAL;
      verdict.kind  = KIND_EQUAL;
      case (state_ff)
         WS_IDLE: begin
            if (go) begin
               i_in     = '0;
               j_in     = '0;
               m_in     = '0;
               l1_in    = lens.first;
               l2_in    = lens.second;
               ml_in    = lens.mask;
               diff_in  = ORDER_EQUAL;
               mskip_in = 1'b0;
            end
         end
         WS_LOOP: begin
            if (loop_end) begin
               verdict.valid = 1'b1;
               if (l1_ff != '0) begin
                  verdict.order = ORDER_SECOND;
                  verdict.kind  = KIND_LONGER;
               end else if (l2_ff != '0) begin
                  verdict.order = ORDER_FIRST;
                  verdict.kind  = KIND_LONGER;
               end else begin
                  verdict.order = diff_ff;
                  verdict.kind  = (diff_ff == ORDER_EQUAL) ? KIND_EQUAL : KIND_MORE_INFO;
               end
            end else if (num_hit) begin
               verdict.valid = 1'b1;
               verdict.order = (a_key > b_key) ? ORDER_FIRST : ORDER_SECOND;
               verdict.kind  = KIND_NUMERIC;
            end else if (end_mis) begin
               // first group-end mismatch decides the tie
               if (diff_ff == ORDER_EQUAL) diff_in = a_end ? ORDER_FIRST : ORDER_SECOND;
            end else if (!(a_end && mask_left)) begin
               if (mask_left && mk_end) mskip_in = 1'b1;
               adv = 1'b1;
            end
         end
         WS_SKIP_SECOND: begin
            if (l2_ff != '0 && !b_end) begin
               j_in  = j_ff + count_type'(1);
               l2_in = l2_ff - count_type'(1);
            end else if (l2_ff == '0) begin
               verdict.valid = 1'b1;
               verdict.order = ORDER_FIRST;
               verdict.kind  = KIND_MALFORMED;
            end else if (!mask_left) begin
               adv = 1'b1;
            end
         end
         WS_SKIP_FIRST: begin
            if (l1_ff != '0 && !a_end) begin
               i_in  = i_ff + count_type'(1);
               l1_in = l1_ff - count_type'(1);
            end else if (l1_ff == '0) begin
               verdict.valid = 1'b1;
               verdict.order = ORDER_SECOND;
               verdict.kind  = KIND_MALFORMED;
            end else if (!mask_left) begin
               adv = 1'b1;
            end
         end
         WS_MASK_SKIP: begin
            if (mask_left && !mk_end) begin
               m_in  = m_ff + count_type'(1);
               ml_in = ml_ff - count_type'(1);
            end else begin
               // step past the mask group end
               if (mask_left) begin
                  m_in     = m_ff + count_type'(1);
                  ml_in    = ml_ff - count_type'(1);
                  mskip_in = (ml_ff == count_type'(1));
               end else begin
                  mskip_in = 1'b1;
               end
               adv = 1'b1;
            end
         end
         default: ;
      endcase
      if (adv) begin
         l1_in = l1_ff - count_type'(1);
         l2_in = l2_ff - count_type'(1);
         if (l1_ff != count_type'(1)) i_in = i_ff + count_type'(1);
         if (l2_ff != count_type'(1)) j_in = j_ff + count_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= WS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff     <= i_in;
      j_ff     <= j_in;
      m_ff     <= m_in;
      l1_ff    <= l1_in;
      l2_ff    <= l2_in;
      ml_ff    <= ml_in;
      diff_ff  <= diff_in;
      mskip_ff <= mskip_in;
   end

endmodule

/* design/mfvc_checker.sv */
module mfvc_checker import mfvc_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic [1:0]        req_opcode,
   input logic              rsp_valid,
   input logic signed [1:0] rsp_order,
   input logic [2:0]        rsp_kind
);

   // compare word raises busy on the next cycle
   a_compare_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == OP_COMPARE) |=> busy)
      else $error("compare accepted without busy");

   // every result follows a busy period
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("result strobe without compare");

   a_busy_ends_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("compare finished without result");

   a_equal_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_EQUAL) |-> (rsp_order == ORDER_EQUAL))
      else $error("equal result with nonzero order");

endmodule

bind masked_feature_vector_compare_core mfvc_checker u_mfvc_checker (.*);

/* test/masked_feature_vector_compare_checker.sv */
module masked_feature_vector_compare_checker import mfvc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [1:0]        req_opcode,
   input  logic [7:0]        req_octet,
   input  logic              rsp_valid,
   input  logic signed [1:0] rsp_order,
   input  logic [2:0]        rsp_kind,
   input  logic              rsp_overflow,
   output int                mismatches,
   output int                pending,
   output int                checked
);

   typedef struct packed {
      logic signed [1:0] order;
      kind_type          kind;
      logic              overflow;
   } verdict_type;

   logic [7:0]  first_buf [MAX_OCTETS];
   logic [7:0]  second_buf [MAX_OCTETS];
   logic [7:0]  mask_buf [MAX_OCTETS];
   int          first_len = 0;
   int          second_len = 0;
   int          mask_len = 0;
   logic        dropped = 1'b0;
   verdict_type expected_verdicts [$];
   verdict_type want;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   // loads past capacity are lost but remembered until the next compare
   function automatic void store_octet(input logic [1:0] op, input logic [7:0] v);
      case (op)
         OP_LOAD_FIRST: begin
            if (first_len < MAX_OCTETS) begin
               first_buf[first_len] = v;
               first_len++;
            end else begin
               dropped = 1'b1;
            end
         end
         OP_LOAD_SECOND: begin
            if (second_len < MAX_OCTETS) begin
               second_buf[second_len] = v;
               second_len++;
            end else begin
               dropped = 1'b1;
            end
         end
         OP_LOAD_MASK: begin
            if (mask_len < MAX_OCTETS) begin
               mask_buf[mask_len] = v;
               mask_len++;
            end else begin
               dropped = 1'b1;
            end
         end
         default: ;
      endcase
   endfunction

   // walk both vectors group by group; the mask tracks the group ends of the first
   function automatic verdict_type rank_vectors();
      int                i, j, m, l1, l2, ml;
      logic signed [1:0] first_split;
      logic              mask_done;
      logic [7:0]        a, b, k;
      verdict_type       res;
      i = 0;
      j = 0;
      m = 0;
      l1 = first_len;
      l2 = second_len;
      ml = mask_len;
      first_split = ORDER_EQUAL;
      mask_done = 1'b0;
      res = '0;
      while (l1 > 0 && l2 > 0) begin
         a = first_buf[i];
         b = second_buf[j];
         if (!mask_done) begin
            k = (ml == 0) ? {1'b0, LOW_MASK} : {1'b0, mask_buf[m][6:0]};
            if (((a ^ b) & k) != 8'h00) begin
               res.order = ((a & k) > (b & k)) ? ORDER_FIRST : ORDER_SECOND;
               res.kind = KIND_NUMERIC;
               return res;
            end
         end
         if (a[7] != b[7]) begin
            if (a[7]) begin
               if (first_split == ORDER_EQUAL) first_split = ORDER_FIRST;
               while (l2 > 0 && !second_buf[j][7]) begin
                  j++;
                  l2--;
               end
               if (l2 == 0) begin
                  res.order = ORDER_FIRST;
                  res.kind = KIND_MALFORMED;
                  return res;
               end
            end else begin
               if (first_split == ORDER_EQUAL) first_split = ORDER_SECOND;
               while (l1 > 0 && !first_buf[i][7]) begin
                  i++;
                  l1--;
               end
               if (l1 == 0) begin
                  res.order = ORDER_SECOND;
                  res.kind = KIND_MALFORMED;
                  return res;
               end
            end
            if (ml > 0) begin
               while (ml > 0 && !mask_buf[m][7]) begin
                  m++;
                  ml--;
               end
               mask_done = (ml == 0);
            end
         end
         if (ml > 0) begin
            if (first_buf[i][7]) begin
               while (ml > 0 && !mask_buf[m][7]) begin
                  m++;
                  ml--;
               end
               if (ml > 0) begin
                  m++;
                  ml--;
               end
               mask_done = (ml == 0);
            end else if (mask_buf[m][7]) begin
               mask_done = 1'b1;
            end
         end
         l1--;
         if (l1 > 0) i++;
         l2--;
         if (l2 > 0) j++;
      end
      if (l1 > 0) begin
         res.order = ORDER_SECOND;
         res.kind = KIND_LONGER;
      end else if (l2 > 0) begin
         res.order = ORDER_FIRST;
         res.kind = KIND_LONGER;
      end else if (first_split != ORDER_EQUAL) begin
         res.order = first_split;
         res.kind = KIND_MORE_INFO;
      end else begin
         res.order = ORDER_EQUAL;
         res.kind = KIND_EQUAL;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         first_len = 0;
         second_len = 0;
         mask_len = 0;
         dropped = 1'b0;
         expected_verdicts.delete();
         pending <= 0;
      end else begin
         // results first: a word accepted on this edge cannot be answered yet
         if (rsp_valid) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch($sformatf("verdict order %0d kind %0d overflow %0d with no compare open",
                                         rsp_order, rsp_kind, rsp_overflow));
            end else begin
               want = expected_verdicts.pop_front();
               checked++;
               if (rsp_order !== want.order || rsp_kind !== want.kind ||
                   rsp_overflow !== want.overflow) begin
                  report_mismatch($sformatf("got order %0d kind %0d overflow %0d, want %0d %0d %0d",
                                            rsp_order, rsp_kind, rsp_overflow,
                                            want.order, want.kind, want.overflow));
               end
            end
         end
         if (start && !busy) begin
            if (req_opcode == OP_COMPARE) begin
               want = rank_vectors();
               want.overflow = dropped;
               expected_verdicts.push_back(want);
               first_len = 0;
               second_len = 0;
               mask_len = 0;
               dropped = 1'b0;
            end else begin
               store_octet(req_opcode, req_octet);
            end
         end
         pending <= expected_verdicts.size();
      end
   end

endmodule

/* test/masked_feature_vector_compare_core_tb.sv */
module masked_feature_vector_compare_core_tb;
   import mfvc_pkg::*;

   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int DRAIN_CYCLES    = 300;
   localparam int WORDS_PER_PHASE = 450;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_opcode = OP_LOAD_FIRST;
   logic [7:0]        req_octet = 8'h00;
   logic              rsp_valid;
   logic signed [1:0] rsp_order;
   logic [2:0]        rsp_kind;
   logic              rsp_overflow;
   int                mismatches;
   int                pending;
   int                checked;
   int                word_count = 0;
   int                compare_count = 0;
   int                idle_cycles = 0;
   int                gap_pct = 0;
   logic [7:0]        vec_a [$];
   logic [7:0]        vec_b [$];
   logic [7:0]        vec_m [$];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   masked_feature_vector_compare_core uut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_opcode   (req_opcode),
      .req_octet    (req_octet),
      .rsp_valid    (rsp_valid),
      .rsp_order    (rsp_order),
      .rsp_kind     (rsp_kind),
      .rsp_overflow (rsp_overflow)
   );

   masked_feature_vector_compare_checker verdict_check (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_opcode   (req_opcode),
      .req_octet    (req_octet),
      .rsp_valid    (rsp_valid),
      .rsp_order    (rsp_order),
      .rsp_kind     (rsp_kind),
      .rsp_overflow (rsp_overflow),
      .mismatches   (mismatches),
      .pending      (pending),
      .checked      (checked)
   );

   // start stays high across back-to-back words; it drops for a gap or while draining
   task automatic send_word(input logic [1:0] op, input logic [7:0] oct);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_octet <= oct;
      @(posedge clock);
      while (busy) @(posedge clock);
      word_count++;
      if (op == OP_COMPARE) compare_count++;
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
   endtask

   // bit 7 closes a group; the last octet usually closes one
   function automatic logic [7:0] group_octet(input bit last);
      logic [31:0] bits;
      logic [7:0]  w;
      bits = $urandom;
      w = bits[7:0];
      w[7] = (bits[9:8] == 2'b00) || (last && bits[12:10] != 3'b000);
      return w;
   endfunction

   task automatic build_vectors();
      int          len, n, pos;
      logic [31:0] bits;
      logic [7:0]  w;
      logic [7:0]  spare [$];
      vec_a.delete();
      vec_b.delete();
      vec_m.delete();
      len = ($urandom_range(15) == 0) ? $urandom_range(32, 12) : $urandom_range(8, 0);
      for (n = 0; n < len; n++) vec_a.push_back(group_octet(n == len - 1));
      vec_b = vec_a;
      // second vector is usually a near copy so the walk gets deep before it diverges
      bits = $urandom;
      pos = (vec_b.size() > 0) ? $urandom_range(vec_b.size() - 1) : 0;
      case (bits[2:0])
         3'd0, 3'd1: begin
            if (vec_b.size() > 0) begin
               w = vec_b[pos];
               w[6:0] = w[6:0] ^ {bits[9:4], 1'b1};
               vec_b[pos] = w;
            end
         end
         3'd2: begin
            if (vec_b.size() > 0) begin
               w = vec_b[pos];
               w[7] = ~w[7];
               vec_b[pos] = w;
            end
         end
         3'd3: begin
            if (vec_b.size() > 0) vec_b.pop_back();
         end
         3'd4: vec_b.push_back(group_octet(bits[10]));
         3'd5: begin
            vec_b.delete();
            len = $urandom_range(8, 0);
            for (n = 0; n < len; n++) vec_b.push_back(group_octet(n == len - 1));
         end
         default: ;
      endcase
      if (bits[31]) begin
         spare = vec_a;
         vec_a = vec_b;
         vec_b = spare;
      end
      bits = $urandom;
      case (bits[1:0])
         2'd1, 2'd2: begin
            for (n = 0; n < vec_a.size(); n++) begin
               bits = $urandom;
               w = bits[0] ? {1'b0, LOW_MASK} : {1'b0, bits[7:1]};
               spare = {vec_a[n]};
               w[7] = spare[0][7];
               vec_m.push_back(w);
            end
            bits = $urandom;
            if (bits[1:0] == 2'd0) begin
               while (vec_m.size() > bits[4:2]) vec_m.pop_back();
            end
         end
         2'd3: begin
            len = $urandom_range(6, 1);
            for (n = 0; n < len; n++) vec_m.push_back(group_octet(n == len - 1));
         end
         default: ;
      endcase
      // now and then overfill one buffer
      bits = $urandom;
      if (bits[3:0] == 4'd0) begin
         len = MAX_OCTETS + 1 + bits[5:4];
         case (bits[7:6])
            2'd0: while (vec_a.size() < len) vec_a.push_back(group_octet(1'b0));
            2'd1: while (vec_b.size() < len) vec_b.push_back(group_octet(1'b0));
            default: while (vec_m.size() < len) vec_m.push_back(group_octet(1'b0));
         endcase
      end
   endtask

   task automatic load_vectors();
      logic [31:0] bits;
      while (vec_a.size() + vec_b.size() + vec_m.size() != 0) begin
         bits = $urandom;
         if (bits[1:0] == 2'd0 && vec_a.size() > 0) begin
            send_word(OP_LOAD_FIRST, vec_a.pop_front());
         end else if (bits[1:0] == 2'd1 && vec_b.size() > 0) begin
            send_word(OP_LOAD_SECOND, vec_b.pop_front());
         end else if (bits[1:0] == 2'd2 && vec_m.size() > 0) begin
            send_word(OP_LOAD_MASK, vec_m.pop_front());
         end
      end
   endtask

   task automatic run_phase(input int pct, input int words);
      int          stop_at, n;
      logic [31:0] bits;
      gap_pct = pct;
      stop_at = word_count + words;
      while (word_count < stop_at) begin
         bits = $urandom;
         if (bits[3:0] == 4'd0) begin
            // noise: random words of any kind
            n = $urandom_range(6, 1);
            repeat (n) begin
               bits = $urandom;
               send_word(bits[1:0], bits[9:2]);
            end
         end else begin
            build_vectors();
            load_vectors();
            send_word(OP_COMPARE, bits[15:8]);
            if (bits[18:16] == 3'd0) wait_drained();
         end
      end
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // nothing loaded
      send_word(OP_COMPARE, 8'h00);
      // low bits differ both ways, octet extremes
      send_word(OP_LOAD_FIRST, 8'h05);
      send_word(OP_LOAD_SECOND, 8'h03);
      send_word(OP_COMPARE, 8'hFF);
      send_word(OP_LOAD_FIRST, 8'h00);
      send_word(OP_LOAD_SECOND, 8'h7F);
      send_word(OP_COMPARE, 8'h00);
      // a zero mask hides everything and is used up at the first group end
      send_word(OP_LOAD_FIRST, 8'hFF);
      send_word(OP_LOAD_SECOND, 8'hFF);
      send_word(OP_LOAD_MASK, 8'h00);
      send_word(OP_COMPARE, 8'h80);
      // one side runs out while skipping to its group end
      send_word(OP_LOAD_FIRST, 8'h01);
      send_word(OP_LOAD_SECOND, 8'h81);
      send_word(OP_COMPARE, 8'h00);
      send_word(OP_LOAD_FIRST, 8'h81);
      send_word(OP_LOAD_SECOND, 8'h01);
      send_word(OP_COMPARE, 8'h00);
      // first ends a group early, lengths line up after the skip
      send_word(OP_LOAD_FIRST, 8'h81);
      send_word(OP_LOAD_FIRST, 8'h83);
      send_word(OP_LOAD_SECOND, 8'h01);
      send_word(OP_LOAD_SECOND, 8'h81);
      send_word(OP_LOAD_SECOND, 8'h83);
      send_word(OP_COMPARE, 8'h00);
      wait_drained();
      run_phase(26, WORDS_PER_PHASE);
      run_phase(57, WORDS_PER_PHASE);
      run_phase(0, WORDS_PER_PHASE);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d words, %0d compares, %0d verdicts checked",
               word_count, compare_count, checked);
      $display("sender gaps of 26, 57 and 0 percent, overfilled buffers and noise words");
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* sim.f */
design/mfvc_pkg.sv
design/mfvc_walk.sv
design/masked_feature_vector_compare_core.sv
design/mfvc_checker.sv
test/masked_feature_vector_compare_checker.sv
test/masked_feature_vector_compare_core_tb.sv
